/* sv/ami_pkg.sv */
// ============================================================================
// ami_pkg: shared types and constants of the affine matrix inverse
// Beat types, sequencer codes, microcode decode and saturation helpers.
// ============================================================================
package ami_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int ACC_W = 66;
  localparam int DET_W = ACC_W - FRACTION_BITS;
  localparam int DIV_W = DET_W + 33;
  localparam int QUO_W = 33;

  localparam logic [31:0] FLAG_IDENTITY = 32'h0002_0000;
  localparam logic [31:0] TYPE_MASK = 32'h0000_0003;
  localparam logic [31:0] TYPE_ORTHONORMAL = 32'h0000_0003;

  localparam int BANK_DEPTH = 24;
  localparam int SEL_W = 5;
  localparam logic [SEL_W-1:0] M_BASE = 5'd0;
  localparam logic [SEL_W-1:0] C_BASE = 5'd12;
  localparam logic [SEL_W-1:0] P_BASE = 5'd21;
  localparam logic [4:0] LAST_A_STEP = 5'd20;
  localparam logic [4:0] NUM_COF_STEPS = 5'd18;
  localparam logic [3:0] LAST_COF = 4'd8;
  localparam logic [1:0] ROW_POS = 2'd3;

  typedef struct packed {
    logic [1:0]         row_select;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic [31:0]        type_flags;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_flags;
    logic               singular;
    logic               last_row;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_A,
    ST_DRAIN_A,
    ST_DIV,
    ST_MAC_B,
    ST_DRAIN_B,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDENT,
    MODE_ORTHO,
    MODE_GEN
  } mode_e;

  typedef enum logic [1:0] {
    WB_COF,
    WB_DET,
    WB_POS
  } wb_e;

  typedef struct packed {
    logic             valid;
    logic [SEL_W-1:0] a_sel;
    logic [SEL_W-1:0] b_sel;
    logic             sub;
    logic             first;
    logic             last;
    wb_e              kind;
    logic [SEL_W-1:0] dst;
  } uop_t;

  // Cofactors and determinant of the 3x3 part, two or three products each.
  function automatic uop_t ucode_a(logic [4:0] step);
    uop_t u;
    logic [3:0] i;
    logic [SEL_W-1:0] a, b, c, d;
    u = '0;
    i = step[4:1];
    a = '0;
    b = '0;
    c = '0;
    d = '0;
    u.valid = 1'b1;
    if (step < NUM_COF_STEPS) begin
      unique case (i)
        4'd0: begin a = 5'd4; b = 5'd8; c = 5'd5; d = 5'd7; end
        4'd1: begin a = 5'd7; b = 5'd2; c = 5'd8; d = 5'd1; end
        4'd2: begin a = 5'd1; b = 5'd5; c = 5'd2; d = 5'd4; end
        4'd3: begin a = 5'd5; b = 5'd6; c = 5'd3; d = 5'd8; end
        4'd4: begin a = 5'd8; b = 5'd0; c = 5'd6; d = 5'd2; end
        4'd5: begin a = 5'd2; b = 5'd3; c = 5'd0; d = 5'd5; end
        4'd6: begin a = 5'd3; b = 5'd7; c = 5'd4; d = 5'd6; end
        4'd7: begin a = 5'd6; b = 5'd1; c = 5'd7; d = 5'd0; end
        default: begin a = 5'd0; b = 5'd4; c = 5'd1; d = 5'd3; end
      endcase
      u.a_sel = step[0] ? c : a;
      u.b_sel = step[0] ? d : b;
      u.sub = step[0];
      u.first = !step[0];
      u.last = step[0];
      u.kind = WB_COF;
      u.dst = C_BASE + SEL_W'(i);
    end else begin
      u.kind = WB_DET;
      u.last = (step == LAST_A_STEP);
      u.first = (step == NUM_COF_STEPS);
      if (step == NUM_COF_STEPS) begin
        u.a_sel = M_BASE + 5'd3;
        u.b_sel = C_BASE + 5'd1;
      end else if (step == LAST_A_STEP) begin
        u.a_sel = C_BASE;
        u.b_sel = M_BASE;
      end else begin
        u.a_sel = M_BASE + 5'd6;
        u.b_sel = C_BASE + 5'd2;
      end
    end
    return u;
  endfunction

  // Projection of the position row onto column pos of the inverse.
  function automatic uop_t ucode_b(logic [1:0] pos, logic [1:0] term, logic ortho);
    uop_t u;
    logic [SEL_W-1:0] p5, t5;
    u = '0;
    p5 = SEL_W'(pos);
    t5 = SEL_W'(term);
    u.valid = 1'b1;
    u.a_sel = M_BASE + 5'd9 + t5;
    u.b_sel = ortho ? (M_BASE + 5'd3 * p5 + t5) : (C_BASE + 5'd3 * t5 + p5);
    u.sub = 1'b0;
    u.first = (term == 2'd0);
    u.last = (term == 2'd2);
    u.kind = WB_POS;
    u.dst = P_BASE + p5;
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

/* sv/ami_div.sv */
// ============================================================================
// ami_div: bit-serial rounded fixed-point divider
// Returns cofactor * 2^F / det, rounded with ties away from zero, saturated
// to 32 bits. One quotient bit per cycle.
// ============================================================================
module ami_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [31:0]                 cof_i,
  input  logic signed [ami_pkg::DET_W-1:0]   det_i,
  output logic                               done_o,
  output logic signed [31:0]                 quo_o
);

  localparam logic [5:0] LastCnt = 6'd34;

  logic                            busy_q;
  logic [5:0]                      cnt_q;
  logic [ami_pkg::DIV_W-1:0]       rem_q, rem_d;
  logic [ami_pkg::DIV_W-1:0]       dsh_q, dsh_d;
  logic [ami_pkg::QUO_W-1:0]       quo_q, quo_d;
  logic                            ovf_q, ovf_d;
  logic                            neg_q;
  logic [31:0]                     mag_c;
  logic signed [32:0]              cof_ext;
  logic [ami_pkg::DET_W-1:0]       mag_d;
  logic                            ge;

  assign cof_ext = 33'(cof_i);
  assign mag_c = cof_i[31] ? 32'(-cof_ext) : 32'(cof_ext);
  assign mag_d = det_i[ami_pkg::DET_W-1] ? ami_pkg::DET_W'(-det_i) : det_i;
  assign ge = (rem_q >= dsh_q);

  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q >> 1;
    quo_d = quo_q;
    ovf_d = ovf_q;
    if (cnt_q == 6'd0) begin
      ovf_d = ge;
    end else if (ge) begin
      rem_d = rem_q - dsh_q;
      quo_d = {quo_q[ami_pkg::QUO_W-2:0], 1'b1};
    end else begin
      quo_d = {quo_q[ami_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= (ami_pkg::DIV_W'(mag_c) << (ami_pkg::FRACTION_BITS + 1))
               + ami_pkg::DIV_W'(mag_d);
      dsh_q <= ami_pkg::DIV_W'(mag_d) << 34;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= cof_i[31] ^ det_i[ami_pkg::DET_W-1];
    end else if (busy_q && cnt_q != LastCnt) begin
      rem_q <= rem_d;
      dsh_q <= dsh_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign done_o = busy_q && (cnt_q == LastCnt);

  always_comb begin
    if (neg_q) begin
      if (ovf_q || quo_q > 33'h0_8000_0000) quo_o = 32'sh8000_0000;
      else quo_o = 32'(-quo_q);
    end else begin
      if (ovf_q || quo_q > 33'h0_7FFF_FFFF) quo_o = 32'sh7FFF_FFFF;
      else quo_o = quo_q[31:0];
    end
  end

endmodule

/* sv/affine_matrix_inverse.sv */
// ============================================================================
// affine_matrix_inverse: 3x4 affine matrix inverse in Q16.16
// Loads four rows, then returns the four rows of the inverse.
// ============================================================================
// Rows 0 to 2 are stored as they are taken while idle. The position row
// starts the inversion and the block takes no beat until all four result
// beats are gone. An identity matrix is returned at once; an orthonormal
// one after nine products on the shared multiplier. A general matrix takes
// 21 products for cofactors and determinant, nine divisions on the
// bit-serial divider and nine more products, most of the time spent in the
// divider.
module affine_matrix_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ami_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ami_pkg::out_beat_t out_beat_o
);

  ami_pkg::state_e state_q, state_d;
  ami_pkg::mode_e  mode_q;
  logic [31:0]     flags_q;
  logic            singular_q;
  logic [4:0]      step_q;
  logic [1:0]      pos_q, term_q;
  logic [3:0]      div_idx_q;
  logic            div_run_q;
  logic [1:0]      out_cnt_q;

  logic signed [31:0] bank_q [ami_pkg::BANK_DEPTH];
  logic signed [ami_pkg::DET_W-1:0] det_q, det_eff;

  ami_pkg::uop_t uop, c1_q, c2_q, c3_q;
  logic signed [31:0] opa_q, opb_q;
  logic signed [63:0] prod_q;
  logic signed [ami_pkg::ACC_W-1:0] acc_q, acc_d, rnd, prod_ext;

  logic in_acc, out_acc, div_start, div_done;
  logic signed [31:0] div_res;
  logic [ami_pkg::SEL_W-1:0] wr_base, div_sel;
  logic [ami_pkg::SEL_W-1:0] out_sel [3];

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign wr_base = ami_pkg::SEL_W'(in_beat_i.row_select) * 5'd3;
  assign div_sel = ami_pkg::C_BASE + ami_pkg::SEL_W'(div_idx_q);
  assign det_eff = singular_q ? ami_pkg::DET_W'(1) << ami_pkg::FRACTION_BITS : det_q;

  always_comb begin
    state_d = state_q;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    div_start = 1'b0;
    uop = '0;
    unique case (state_q)
      ami_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_beat_i.row_select == ami_pkg::ROW_POS) begin
          if ((in_beat_i.type_flags & ami_pkg::FLAG_IDENTITY) != '0) begin
            state_d = ami_pkg::ST_OUT;
          end else if ((in_beat_i.type_flags & ami_pkg::TYPE_MASK)
                       == ami_pkg::TYPE_ORTHONORMAL) begin
            state_d = ami_pkg::ST_MAC_B;
          end else begin
            state_d = ami_pkg::ST_MAC_A;
          end
        end
      end
      ami_pkg::ST_MAC_A: begin
        uop = ami_pkg::ucode_a(step_q);
        if (step_q == ami_pkg::LAST_A_STEP) state_d = ami_pkg::ST_DRAIN_A;
      end
      ami_pkg::ST_DRAIN_A: begin
        if (!c1_q.valid && !c2_q.valid && !c3_q.valid) state_d = ami_pkg::ST_DIV;
      end
      ami_pkg::ST_DIV: begin
        div_start = !div_run_q;
        if (div_done && div_idx_q == ami_pkg::LAST_COF) state_d = ami_pkg::ST_MAC_B;
      end
      ami_pkg::ST_MAC_B: begin
        uop = ami_pkg::ucode_b(pos_q, term_q, mode_q == ami_pkg::MODE_ORTHO);
        if (pos_q == 2'd2 && term_q == 2'd2) state_d = ami_pkg::ST_DRAIN_B;
      end
      ami_pkg::ST_DRAIN_B: begin
        if (!c1_q.valid && !c2_q.valid && !c3_q.valid) state_d = ami_pkg::ST_OUT;
      end
      ami_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i && out_cnt_q == 2'd3) state_d = ami_pkg::ST_IDLE;
      end
      default: state_d = ami_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ami_pkg::ST_IDLE;
      mode_q <= ami_pkg::MODE_IDENT;
      flags_q <= '0;
      singular_q <= 1'b0;
      step_q <= '0;
      pos_q <= '0;
      term_q <= '0;
      div_idx_q <= '0;
      div_run_q <= 1'b0;
      out_cnt_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else begin
      state_q <= state_d;
      c1_q <= uop;
      c2_q <= c1_q;
      c3_q <= c2_q;
      if (in_acc && in_beat_i.row_select == ami_pkg::ROW_POS) begin
        step_q <= '0;
        pos_q <= '0;
        term_q <= '0;
        div_idx_q <= '0;
        div_run_q <= 1'b0;
        out_cnt_q <= '0;
        singular_q <= 1'b0;
        if ((in_beat_i.type_flags & ami_pkg::FLAG_IDENTITY) != '0) begin
          mode_q <= ami_pkg::MODE_IDENT;
          flags_q <= in_beat_i.type_flags;
        end else if ((in_beat_i.type_flags & ami_pkg::TYPE_MASK)
                     == ami_pkg::TYPE_ORTHONORMAL) begin
          mode_q <= ami_pkg::MODE_ORTHO;
          flags_q <= ami_pkg::TYPE_ORTHONORMAL;
        end else begin
          mode_q <= ami_pkg::MODE_GEN;
          flags_q <= in_beat_i.type_flags & ~ami_pkg::FLAG_IDENTITY;
        end
      end
      if (state_q == ami_pkg::ST_MAC_A) step_q <= step_q + 5'd1;
      if (state_q == ami_pkg::ST_DRAIN_A && state_d == ami_pkg::ST_DIV) begin
        singular_q <= (det_q == '0);
      end
      if (div_start) div_run_q <= 1'b1;
      if (div_done) begin
        div_run_q <= 1'b0;
        div_idx_q <= div_idx_q + 4'd1;
      end
      if (state_q == ami_pkg::ST_MAC_B) begin
        if (term_q == 2'd2) begin
          term_q <= '0;
          pos_q <= pos_q + 2'd1;
        end else begin
          term_q <= term_q + 2'd1;
        end
      end
      if (out_acc) out_cnt_q <= out_cnt_q + 2'd1;
    end
  end

  assign prod_ext = ami_pkg::ACC_W'(prod_q);
  assign acc_d = (c2_q.first ? '0 : acc_q) + (c2_q.sub ? -prod_ext : prod_ext);
  assign rnd = (acc_q + (ami_pkg::ACC_W'(1) << (ami_pkg::FRACTION_BITS - 1)))
               >>> ami_pkg::FRACTION_BITS;

  always_ff @(posedge clk_i) begin
    opa_q <= bank_q[uop.a_sel];
    opb_q <= bank_q[uop.b_sel];
    prod_q <= opa_q * opb_q;
    if (c2_q.valid) acc_q <= acc_d;
    if (c3_q.valid && c3_q.last && c3_q.kind == ami_pkg::WB_DET) begin
      det_q <= rnd[ami_pkg::DET_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bank_q[wr_base] <= in_beat_i.elem_x;
      bank_q[wr_base + 5'd1] <= in_beat_i.elem_y;
      bank_q[wr_base + 5'd2] <= in_beat_i.elem_z;
    end
    if (c3_q.valid && c3_q.last) begin
      unique case (c3_q.kind)
        ami_pkg::WB_COF: bank_q[c3_q.dst] <= ami_pkg::sat32(rnd);
        ami_pkg::WB_POS: bank_q[c3_q.dst] <= ami_pkg::sat32(-rnd);
        default: ;
      endcase
    end
    if (div_done) bank_q[div_sel] <= div_res;
  end

  ami_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cof_i   (bank_q[div_sel]),
    .det_i   (det_eff),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      unique case (mode_q)
        ami_pkg::MODE_IDENT:
          out_sel[j] = 5'd3 * ami_pkg::SEL_W'(out_cnt_q) + ami_pkg::SEL_W'(j);
        ami_pkg::MODE_ORTHO:
          out_sel[j] = (out_cnt_q == 2'd3) ? ami_pkg::P_BASE + ami_pkg::SEL_W'(j)
                     : 5'd3 * ami_pkg::SEL_W'(j) + ami_pkg::SEL_W'(out_cnt_q);
        default:
          out_sel[j] = (out_cnt_q == 2'd3) ? ami_pkg::P_BASE + ami_pkg::SEL_W'(j)
                     : ami_pkg::C_BASE + 5'd3 * ami_pkg::SEL_W'(out_cnt_q)
                       + ami_pkg::SEL_W'(j);
      endcase
    end
  end

  assign out_beat_o.out_row = out_cnt_q;
  assign out_beat_o.out_x = bank_q[out_sel[0]];
  assign out_beat_o.out_y = bank_q[out_sel[1]];
  assign out_beat_o.out_z = bank_q[out_sel[2]];
  assign out_beat_o.out_flags = flags_q;
  assign out_beat_o.singular = singular_q;
  assign out_beat_o.last_row = (out_cnt_q == 2'd3);

  a_no_input_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("Input beat taken while results pending.");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ami_pkg::ST_DIV) else $error("Divider finished outside divide phase.");

  a_pipe_only_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c3_q.valid |-> (state_q == ami_pkg::ST_MAC_A || state_q == ami_pkg::ST_DRAIN_A ||
                    state_q == ami_pkg::ST_MAC_B || state_q == ami_pkg::ST_DRAIN_B))
    else $error("Multiplier result outside a product phase.");

  a_last_beat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_beat_o.last_row) |=> !out_valid_o)
    else $error("Output still valid after the last beat.");

endmodule

/* test/affine_matrix_inverse_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// affine_matrix_inverse_tb: self-checking bench for the affine matrix inverse
// Random and directed row beats go in through a bursty driver. A predictor
// computes the four expected result rows for each position beat, and a
// monitor under random stall compares every result beat as a whole.
// ============================================================================
module affine_matrix_inverse_tb;

  localparam int FB = ami_pkg::FRACTION_BITS;
  localparam int MAX_CYCLES = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  ami_pkg::in_beat_t in_beat_i;
  logic out_valid_o;
  logic out_stall_i;
  ami_pkg::out_beat_t out_beat_o;

  ami_pkg::in_beat_t pending_rows[$];
  ami_pkg::out_beat_t expected_rows[$];
  logic signed [31:0] mat_shadow[12];
  int errors;
  int cycles;
  int burst_left;
  int gap_left;
  logic hold_off;
  logic pressure_done;
  logic stall_mode;

  affine_matrix_inverse u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o(out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint shr_floor(longint v);
    return v >>> FB;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_dot(longint a0, longint b0, longint a1, longint b1,
                                       longint a2, longint b2);
    longint p0, p1, p2, hi, lo, msk;
    msk = (64'sd1 <<< FB) - 1;
    p0 = a0 * b0;
    p1 = a1 * b1;
    p2 = a2 * b2;
    hi = shr_floor(p0) + shr_floor(p1) + shr_floor(p2);
    lo = (64'sd1 <<< (FB - 1)) + (p0 & msk) + (p1 & msk) + (p2 & msk);
    return hi + (lo >>> FB);
  endfunction

  function automatic longint cof_term(longint a, longint b, longint c, longint d);
    return sat_word(round_dot(a, b, -c, d, 0, 0));
  endfunction

  function automatic longint div_round(longint cof, longint det);
    longint n, un, ud, q;
    logic neg;
    n = cof <<< FB;
    neg = (n < 0) != (det < 0);
    un = n < 0 ? -n : n;
    ud = det < 0 ? -det : det;
    q = (2 * un + ud) / (2 * ud);
    return sat_word(neg ? -q : q);
  endfunction

  task automatic predict_inverse(ami_pkg::in_beat_t b);
    longint m[12];
    longint res[12];
    longint c[9];
    longint det;
    logic [31:0] oflags;
    logic sing;
    ami_pkg::out_beat_t o;
    mat_shadow[b.row_select * 3 + 0] = b.elem_x;
    mat_shadow[b.row_select * 3 + 1] = b.elem_y;
    mat_shadow[b.row_select * 3 + 2] = b.elem_z;
    if (b.row_select != ami_pkg::ROW_POS) return;
    for (int i = 0; i < 12; i++) m[i] = mat_shadow[i];
    sing = 1'b0;
    if ((b.type_flags & ami_pkg::FLAG_IDENTITY) != 0) begin
      for (int i = 0; i < 12; i++) res[i] = m[i];
      oflags = b.type_flags;
    end else if ((b.type_flags & ami_pkg::TYPE_MASK) == ami_pkg::TYPE_ORTHONORMAL) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) res[r * 3 + k] = m[k * 3 + r];
      for (int r = 0; r < 3; r++)
        res[9 + r] = sat_word(-round_dot(m[9], m[r * 3], m[10], m[r * 3 + 1],
                                         m[11], m[r * 3 + 2]));
      oflags = ami_pkg::TYPE_ORTHONORMAL;
    end else begin
      c[0] = cof_term(m[4], m[8], m[5], m[7]);
      c[1] = cof_term(m[7], m[2], m[8], m[1]);
      c[2] = cof_term(m[1], m[5], m[2], m[4]);
      c[3] = cof_term(m[5], m[6], m[3], m[8]);
      c[4] = cof_term(m[8], m[0], m[6], m[2]);
      c[5] = cof_term(m[2], m[3], m[0], m[5]);
      c[6] = cof_term(m[3], m[7], m[4], m[6]);
      c[7] = cof_term(m[6], m[1], m[7], m[0]);
      c[8] = cof_term(m[0], m[4], m[1], m[3]);
      det = round_dot(m[3], c[1], m[6], c[2], c[0], m[0]);
      if (det == 0) begin
        det = 64'sd1 <<< FB;
        sing = 1'b1;
      end
      for (int i = 0; i < 9; i++) res[i] = div_round(c[i], det);
      for (int i = 0; i < 3; i++)
        res[9 + i] = sat_word(-round_dot(m[9], res[i], m[10], res[3 + i],
                                         m[11], res[6 + i]));
      oflags = b.type_flags & ~ami_pkg::FLAG_IDENTITY;
    end
    for (int k = 0; k < 4; k++) begin
      o.out_row = k[1:0];
      o.out_x = res[k * 3][31:0];
      o.out_y = res[k * 3 + 1][31:0];
      o.out_z = res[k * 3 + 2][31:0];
      o.out_flags = oflags;
      o.singular = sing;
      o.last_row = (k == 3);
      expected_rows.push_back(o);
    end
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
    endcase
  endfunction

  function automatic logic [31:0] rand_flags();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 3))
      0: f = f | ami_pkg::FLAG_IDENTITY;
      1: f = (f & ~ami_pkg::FLAG_IDENTITY) | ami_pkg::TYPE_ORTHONORMAL;
      default: f = f & ~ami_pkg::FLAG_IDENTITY;
    endcase
    return f;
  endfunction

  task automatic add_row(logic [1:0] r, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [31:0] f);
    ami_pkg::in_beat_t b;
    b.row_select = r;
    b.elem_x = x;
    b.elem_y = y;
    b.elem_z = z;
    b.type_flags = f;
    pending_rows.push_back(b);
  endtask

  task automatic add_matrix(logic [31:0] e[12], logic [31:0] f);
    for (int r = 0; r < 4; r++) add_row(r[1:0], e[r * 3], e[r * 3 + 1], e[r * 3 + 2],
                                        r == 3 ? f : $urandom);
  endtask

  initial begin
    logic [31:0] e[12];
    logic [31:0] one;
    one = 32'h1 << FB;
    foreach (e[i]) e[i] = 0;
    e[0] = one; e[4] = one; e[8] = one; e[9] = 3 * one; e[10] = -one; e[11] = 32'h8000;
    add_matrix(e, ami_pkg::FLAG_IDENTITY);
    add_matrix(e, ami_pkg::TYPE_ORTHONORMAL);
    add_matrix(e, 32'h0);
    e[4] = 0;
    add_matrix(e, 32'hFFFD_FFFE);
    foreach (e[i]) e[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    add_matrix(e, 32'hFFFF_FFFF);
    add_matrix(e, 32'h1);
    foreach (e[i]) e[i] = 0;
    e[0] = 1; e[4] = 1; e[8] = 1;
    add_matrix(e, 32'h2);
    while (pending_rows.size() < 150) begin
      if ($urandom_range(0, 9) == 0) begin
        add_row(2'($urandom), rand_elem(), rand_elem(), rand_elem(), rand_flags());
      end else begin
        foreach (e[i]) e[i] = rand_elem();
        add_matrix(e, rand_flags());
      end
    end
    // A final full matrix writes every row of the store and ends the queue with row 3.
    foreach (e[i]) e[i] = rand_elem();
    add_matrix(e, rand_flags());
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic fire;
    logic hold_d;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_beat_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
      hold_off <= 1'b0;
      pressure_done <= 1'b0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      hold_d = hold_off;
      if (fire) begin
        predict_inverse(in_beat_i);
        void'(pending_rows.pop_front());
        if (!pressure_done && in_beat_i.row_select == ami_pkg::ROW_POS &&
            pending_rows.size() <= 75) begin
          hold_d = 1'b1;
          pressure_done <= 1'b1;
        end
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (hold_d && expected_rows.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
        hold_d = 1'b0;
      end else begin
        hold_d = 1'b0;
        if (pending_rows.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_beat_i <= pending_rows[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      hold_off <= hold_d;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ami_pkg::out_beat_t exp_row;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode <= 1'b0;
      errors <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      out_stall_i <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
      if (out_valid_o && !out_stall_i) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_beat_o);
          errors <= errors + 1;
        end else begin
          exp_row = expected_rows.pop_front();
          if (out_beat_o !== exp_row) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_row, out_beat_o);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while ((pending_rows.size() != 0 || expected_rows.size() != 0) && cycles < MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (400) @(posedge clk_i);
      if (errors == 0 && expected_rows.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule
